// File: rtl/ctr_pkg.sv
// shared types and sizes for the cosine threshold recommender
// no dependencies
package ctr_pkg;

  localparam int unsigned MaxUsers = 16;
  localparam int unsigned MaxItems = 16;
  localparam int unsigned MaxDense = 8;
  localparam int unsigned AddrW    = $clog2(MaxUsers * MaxItems);

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatNoSim   = 2'd1;
  localparam logic [1:0] StatBadIdx  = 2'd2;

  localparam logic [1:0] RegThresh = 2'd0;
  localparam logic [1:0] RegUsers  = 2'd1;
  localparam logic [1:0] RegDense  = 2'd2;
  localparam logic [1:0] RegItems  = 2'd3;

  typedef struct packed {
    logic       operation;
    logic [3:0] user;
    logic [3:0] item;
    logic [2:0] rating;
  } ctr_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  similar_count;
    logic [6:0]  rating_sum;
    logic [10:0] average_q8;
  } ctr_res_t;

endpackage

// File: rtl/cosine_threshold_recommender_core.sv
// cosine threshold recommender: rating store, similarity sweep, average divider
// depends on ctr_pkg
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+----------------
//  command   | start && !busy                | cmd_i
//  result    | res_valid_o (one cycle)       | res_o
//  config    | psel && penable && pwrite     | paddr, pwdata
//
// a load leaves busy low, so loads go back to back.
// a query reads the rating memory one entry a cycle: the queried row, then for
// each other user its row and its rating of the queried item, then the M1, M2
// and CMP steps; the queried user is skipped; then the restoring divider runs
// (skipped when no user is similar); the result follows in the next cycle.
// reset clears the per-entry valid bits; unwritten entries read as zero.
// the receiver cannot stall; each result is shown for exactly one cycle.
module cosine_threshold_recommender_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ctr_pkg::ctr_cmd_t cmd_i,
  output logic              res_valid_o,
  output ctr_pkg::ctr_res_t res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import ctr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDA   = 3'd1;
  localparam logic [2:0] S_NEXTB = 3'd2;
  localparam logic [2:0] S_RDB   = 3'd3;
  localparam logic [2:0] S_M1    = 3'd4;
  localparam logic [2:0] S_M2    = 3'd5;
  localparam logic [2:0] S_CMP   = 3'd6;
  localparam logic [2:0] S_DIV   = 3'd7;

  // configuration
  logic [15:0] thr_q;
  logic [4:0]  ucnt_q, icnt_q;
  logic [3:0]  dcnt_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= 16'd57016;
      ucnt_q <= 5'd10;
      dcnt_q <= 4'd5;
      icnt_q <= 5'd10;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegThresh: thr_q  <= pwdata[15:0];
        RegUsers:  ucnt_q <= pwdata[4:0];
        RegDense:  dcnt_q <= pwdata[3:0];
        RegItems:  icnt_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegThresh: prdata = {16'd0, thr_q};
      RegUsers:  prdata = {27'd0, ucnt_q};
      RegDense:  prdata = {28'd0, dcnt_q};
      RegItems:  prdata = {27'd0, icnt_q};
      default:   prdata = 32'd0;
    endcase
  end

  // effective counts
  logic [4:0] nu, ni, nd, d0;
  assign nu = (ucnt_q > 5'(MaxUsers)) ? 5'(MaxUsers) : ucnt_q;
  assign ni = (icnt_q > 5'(MaxItems)) ? 5'(MaxItems) : icnt_q;
  assign d0 = ({1'b0, dcnt_q} > 5'(MaxDense)) ? 5'(MaxDense) : {1'b0, dcnt_q};
  assign nd = (d0 > ni) ? ni : d0;

  // control state
  logic [2:0]  state_q, state_d;
  logic [3:0]  ua_q, item_q;
  logic [4:0]  b_q;
  logic [4:0]  idx_q;
  logic        pend_q;
  logic [4:0]  tag_q;
  logic [2:0]  arow_q [MaxDense];
  logic [8:0]  da_q, db_q, num_q;
  logic [2:0]  sp_q;
  logic [31:0] thr2_q;
  logic [17:0] num2_q, dadb_q;
  logic        zero_q;
  logic [49:0] prod_q;
  logic [3:0]  cnt_q;
  logic [6:0]  sum_q;
  logic [14:0] dvd_q;
  logic [3:0]  rem_q;
  logic [3:0]  step_q;
  logic        res_valid_q;
  ctr_res_t    res_q;

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  logic accept, is_load, is_query, bad_idx;
  assign accept   = start && !busy;
  assign is_load  = accept && (cmd_i.operation == OpLoad);
  assign is_query = accept && (cmd_i.operation == OpQuery);
  assign bad_idx  = ({1'b0, cmd_i.user} >= nu) || ({1'b0, cmd_i.item} >= (ni - nd));

  // rating memory with per-entry valid bits
  logic [2:0]       mem_q [MaxUsers * MaxItems];
  logic [2:0]       rdata_q;
  logic             rvld_q;
  logic [MaxUsers*MaxItems-1:0] vld_q;
  logic             we, re;
  logic [AddrW-1:0] waddr, raddr;
  logic [3:0]       rd_item;
  logic [3:0]       rd_user;
  logic [2:0]       rd;

  assign we    = is_load && ({1'b0, cmd_i.user} < nu) && ({1'b0, cmd_i.item} < ni);
  assign waddr = {cmd_i.user, cmd_i.item};

  always_comb begin
    re      = 1'b0;
    rd_user = ua_q;
    rd_item = idx_q[3:0];
    if (state_q == S_RDA) begin
      re = (idx_q < nd);
    end else if (state_q == S_RDB) begin
      re      = (idx_q <= nd);
      rd_user = b_q[3:0];
      rd_item = (idx_q == nd) ? 4'(nd + {1'b0, item_q}) : idx_q[3:0];
    end
  end
  assign raddr = {rd_user, rd_item};

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= cmd_i.rating;
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we) vld_q[waddr] <= 1'b1;
      rvld_q <= vld_q[raddr];
    end
  end

  assign rd = rvld_q ? rdata_q : 3'd0;

  // divider step
  logic [4:0] dtrial;
  logic       dge;
  assign dtrial = {rem_q, dvd_q[14]};
  assign dge    = dtrial >= {1'b0, cnt_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (is_query && !bad_idx) state_d = S_RDA;
      S_RDA:   if (idx_q == nd && !pend_q) state_d = S_NEXTB;
      S_NEXTB: begin
        if (b_q == nu) state_d = (cnt_q == 4'd0) ? S_IDLE : S_DIV;
        else if (b_q[3:0] != ua_q) state_d = S_RDB;
      end
      S_RDB:   if (idx_q == nd + 5'd1 && !pend_q) state_d = S_M1;
      S_M1:    state_d = S_M2;
      S_M2:    state_d = S_CMP;
      S_CMP:   state_d = S_NEXTB;
      S_DIV:   if (step_q == 4'd14) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= 1'b0;
      pend_q      <= re;
      if (is_query && bad_idx) res_valid_q <= 1'b1;
      if (state_q == S_NEXTB && b_q == nu && cnt_q == 4'd0) res_valid_q <= 1'b1;
      if (state_q == S_DIV && step_q == 4'd14) res_valid_q <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    tag_q <= idx_q;
    if (re) idx_q <= idx_q + 5'd1;
    case (state_q)
      S_IDLE: begin
        ua_q   <= cmd_i.user;
        item_q <= cmd_i.item;
        idx_q  <= 5'd0;
        da_q   <= 9'd0;
        b_q    <= 5'd0;
        cnt_q  <= 4'd0;
        sum_q  <= 7'd0;
        if (is_query && bad_idx) res_q <= '{StatBadIdx, 4'd0, 7'd0, 11'd0};
      end
      S_RDA: begin
        thr2_q <= thr_q * thr_q;
        if (pend_q) begin
          arow_q[tag_q[2:0]] <= rd;
          da_q <= da_q + 9'(rd) * 9'(rd);
        end
      end
      S_NEXTB: begin
        idx_q  <= 5'd0;
        num_q  <= 9'd0;
        db_q   <= 9'd0;
        step_q <= 4'd0;
        rem_q  <= 4'd0;
        dvd_q  <= {sum_q, 8'd0};
        if (b_q != nu && b_q[3:0] == ua_q) b_q <= b_q + 5'd1;
        if (b_q == nu && cnt_q == 4'd0) res_q <= '{StatNoSim, 4'd0, 7'd0, 11'd0};
      end
      S_RDB: begin
        if (pend_q) begin
          if (tag_q < nd) begin
            num_q <= num_q + 9'(arow_q[tag_q[2:0]]) * 9'(rd);
            db_q  <= db_q + 9'(rd) * 9'(rd);
          end else begin
            sp_q <= rd;
          end
        end
      end
      S_M1: begin
        num2_q <= num_q * num_q;
        dadb_q <= da_q * db_q;
        zero_q <= (da_q == 9'd0) || (db_q == 9'd0);
      end
      S_M2: prod_q <= thr2_q * dadb_q;
      S_CMP: begin
        b_q <= b_q + 5'd1;
        if (!zero_q && ({num2_q, 32'd0} >= prod_q)) begin
          cnt_q <= cnt_q + 4'd1;
          sum_q <= sum_q + {4'd0, sp_q};
        end
      end
      S_DIV: begin
        step_q <= step_q + 4'd1;
        rem_q  <= dge ? 4'(dtrial - {1'b0, cnt_q}) : dtrial[3:0];
        dvd_q  <= {dvd_q[13:0], dge};
        if (step_q == 4'd14) begin
          res_q <= '{StatOk, cnt_q, sum_q, {dvd_q[9:0], dge}};
        end
      end
      default: ;
    endcase
  end

endmodule
